// File: hdl/rgbhr_pkg.sv
// Package for the RGB hue rotation block: shared widths, defaults and register codes.
`timescale 1ns / 1ps
`default_nettype none
package rgbhr_pkg;

   // Default fraction width of hue, saturation and lightness.
   localparam int HUE_BITS_DEF = 16;

   // Divider operand width: numerators and divisors never exceed 6*255.
   localparam int DIV_W = 11;

   // Register index decoded from the word address.
   localparam logic REG_HUE_SHIFT = 1'b0;

   // Hue advance per channel in sixths of a turn: red, green, blue.
   localparam logic [2:0] CH_OFS [3] = '{3'd2, 3'd0, 3'd4};

endpackage
`default_nettype wire

// File: hdl/rgbhr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rgbhr_div
   import rgbhr_pkg::*;
#(
   parameter int STEPS = HUE_BITS_DEF + 2
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic [STEPS-1:0] quo
);

   logic [DIV_W:0]   rem_ff [STEPS-1];
   logic [DIV_W-1:0] den_ff [STEPS-1];
   logic [STEPS-1:0] quo_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_stage
      logic [DIV_W:0]   rem_cur;
      logic [DIV_W-1:0] den_cur;
      logic [STEPS-1:0] quo_cur;
      logic             ge;
      logic [DIV_W:0]   red;
      logic [STEPS-1:0] quo_in;

      if (i == 0) begin : g_first
         assign rem_cur = {1'b0, num};
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign quo_cur = quo_ff[i-1];
      end

      assign ge     = rem_cur >= {1'b0, den_cur};
      assign red    = ge ? (rem_cur - {1'b0, den_cur}) : rem_cur;
      assign quo_in = {quo_cur[STEPS-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            quo_ff[i] <= quo_in;
         end
      end

      if (i < STEPS - 1) begin : g_carry
         logic [DIV_W:0] rem_in;
         assign rem_in = {red[DIV_W-1:0], 1'b0};
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[i] <= rem_in;
               den_ff[i] <= den_cur;
            end
         end
      end
   end

   assign quo = quo_ff[STEPS-1];

endmodule
`default_nettype wire

// File: hdl/rgb_hue_rotate_via_hsl.sv
// Top level: RGB to HSL, hue rotation, HSL back to RGB, fully pipelined.
`timescale 1ns / 1ps
`default_nettype none
// Takes one 8-bit RGB pixel per clock and returns it with its hue rotated by
// hue_shift (fraction of a turn times 65536, register at byte address 0).
// Grey pixels come back unchanged. Throughput is one pixel per cycle; the
// pipeline holds one input stage, then HUE_BITS+2 stages for the saturation
// and hue dividers, which resolve one quotient bit per stage while lightness
// comes from a reciprocal multiply alongside, then seven stages of multiply
// and round. A stall on the result side freezes the whole pipeline and drops
// req_ready in the same cycle; nothing is lost or repeated.
module rgb_hue_rotate_via_hsl
   import rgbhr_pkg::*;
#(
   parameter int HUE_BITS = HUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int HB    = HUE_BITS;
   localparam int LW    = HB + 1;
   localparam int STEPS = HB + 2;
   localparam int Q2W   = 2 * HB + 3;
   localparam int UW    = HB + 4;
   localparam int MW    = 2 * LW;
   localparam int VW    = MW + 8;
   localparam int UP    = (HB >= 16) ? HB - 16 : 0;
   localparam int DN    = (HB < 16) ? 16 - HB : 0;
   localparam int SHW   = HB + 17;
   localparam int RCW   = HB + 10;
   localparam logic [SHW-1:0] RNDV = (DN > 0) ? (SHW'(1) << ((DN > 0) ? DN - 1 : 0)) : '0;
   localparam logic [LW-1:0]  ONE_L = {1'b1, {HB{1'b0}}};
   localparam logic [UW-1:0]  ONE_U = UW'(1) << HB;
   // ceil(2^(HB+17)/255): sum*2^HB/255 exact after a 17-bit shift for sums up to 510
   localparam logic [RCW-1:0] LUM_RCP = RCW'(((64'd1 << (HB + 17)) + 64'd254) / 64'd255);

   // ---------------- configuration ----------------
   logic [15:0]    hue_shift_ff;
   logic [SHW-1:0] shift_wide;
   logic [HB-1:0]  shift_hb;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_shift_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_HUE_SHIFT) begin
         hue_shift_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_HUE_SHIFT) ? {16'd0, hue_shift_ff} : '0;

   // Rescale the 16-bit turn fraction to HB bits, rounding when narrowing.
   assign shift_wide = ((SHW'(hue_shift_ff) << UP) + RNDV) >> DN;
   assign shift_hb   = shift_wide[HB-1:0];

   // ---------------- flow control ----------------
   logic h_vld_ff;
   logic adv;

   assign adv       = !h_vld_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = h_vld_ff;

   // ---------------- stage a: max, min and divider operands ----------------
   logic              a_vld_ff;
   logic [8:0]        a_sum_ff;
   logic [DIV_W-1:0]  a_diff_x, a_den_x, a_num_ff, a_d6_ff;
   logic [7:0]        a_diff_ff;
   logic [8:0]        a_den_ff;
   logic              a_grey_ff;
   logic [7:0]        mx, mn, dif;
   logic [8:0]        sm, dn_v;
   logic [DIV_W-1:0]  num_in, d6_in, dx;

   always_comb begin
      mx = req_red_in;
      mn = req_red_in;
      if (req_green_in > mx) mx = req_green_in;
      if (req_blue_in > mx)  mx = req_blue_in;
      if (req_green_in < mn) mn = req_green_in;
      if (req_blue_in < mn)  mn = req_blue_in;
      dif   = mx - mn;
      sm    = {1'b0, mx} + {1'b0, mn};
      dn_v  = (sm <= 9'd255) ? sm : (9'd510 - sm);
      dx    = DIV_W'(dif);
      d6_in = (dx << 2) + (dx << 1);
      if (mx == req_red_in) begin
         if (req_green_in >= req_blue_in) begin
            num_in = DIV_W'(req_green_in) - DIV_W'(req_blue_in);
         end else begin
            num_in = d6_in - (DIV_W'(req_blue_in) - DIV_W'(req_green_in));
         end
      end else if (mx == req_green_in) begin
         num_in = (dx << 1) + DIV_W'(req_blue_in) - DIV_W'(req_red_in);
      end else begin
         num_in = (dx << 2) + DIV_W'(req_red_in) - DIV_W'(req_green_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_sum_ff  <= sm;
         a_diff_ff <= dif;
         a_den_ff  <= dn_v;
         a_num_ff  <= num_in;
         a_d6_ff   <= d6_in;
         a_grey_ff <= (dif == 8'd0);
      end
   end

   assign a_diff_x = DIV_W'(a_diff_ff);
   assign a_den_x  = DIV_W'(a_den_ff);

   // ---------------- dividers: floor(x * 2^(HB+1) / y) ----------------
   logic [STEPS-1:0] t_lum, t_sat, t_hue;

   rgbhr_div #(.STEPS(STEPS)) u_div_sat (
      .clock(clock), .adv(adv), .num(a_diff_x), .den(a_den_x), .quo(t_sat)
   );
   rgbhr_div #(.STEPS(STEPS)) u_div_hue (
      .clock(clock), .adv(adv), .num(a_num_ff), .den(a_d6_ff), .quo(t_hue)
   );

   // Lightness divides by a constant: carry the sum along, multiply in the last slot.
   logic [8:0]       dly_sum_ff [STEPS-1];
   logic [STEPS-1:0] t_lum_ff;
   logic [RCW+8:0]   lum_prod;

   assign lum_prod = (RCW+9)'(dly_sum_ff[STEPS-2]) * (RCW+9)'(LUM_RCP);

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_sum_ff[0] <= a_sum_ff;
         for (int i = 1; i < STEPS - 1; i++) dly_sum_ff[i] <= dly_sum_ff[i-1];
         t_lum_ff <= lum_prod[RCW+8:17];
      end
   end

   assign t_lum = t_lum_ff;

   logic dly_vld_ff  [STEPS];
   logic dly_grey_ff [STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STEPS; i++) dly_vld_ff[i] <= 1'b0;
      end else if (adv) begin
         dly_vld_ff[0] <= a_vld_ff;
         for (int i = 1; i < STEPS; i++) dly_vld_ff[i] <= dly_vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_grey_ff[0] <= a_grey_ff;
         for (int i = 1; i < STEPS; i++) dly_grey_ff[i] <= dly_grey_ff[i-1];
      end
   end

   // ---------------- stage b: round quotients, rotate hue ----------------
   logic          b_vld_ff;
   logic [LW-1:0] b_lum_ff, b_sat_ff;
   logic [HB-1:0] b_hs_ff;
   logic [STEPS:0] rl, rs, rh;
   logic           grey_d;

   assign grey_d = dly_grey_ff[STEPS-1];
   assign rl = ({1'b0, t_lum} + (STEPS+1)'(1)) >> 1;
   assign rs = ({1'b0, t_sat} + (STEPS+1)'(1)) >> 1;
   assign rh = ({1'b0, t_hue} + (STEPS+1)'(1)) >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= dly_vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_lum_ff <= rl[LW-1:0];
         b_sat_ff <= grey_d ? '0 : rs[LW-1:0];
         b_hs_ff  <= (grey_d ? '0 : rh[HB-1:0]) + shift_hb;
      end
   end

   // ---------------- stage c: L*S ----------------
   logic          c_vld_ff;
   logic [LW-1:0] c_lum_ff, c_sat_ff;
   logic [HB-1:0] c_hs_ff;
   logic [MW-1:0] c_ls_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ls_ff  <= MW'(b_lum_ff) * MW'(b_sat_ff);
         c_lum_ff <= b_lum_ff;
         c_sat_ff <= b_sat_ff;
         c_hs_ff  <= b_hs_ff;
      end
   end

   // ---------------- stage d: q and p ----------------
   logic          d_vld_ff;
   logic [LW-1:0] d_q_ff, d_p_ff;
   logic [HB-1:0] d_hs_ff;
   logic [Q2W-1:0] q2, q2r, lum_sh;
   logic [LW-1:0]  q_v;
   logic [LW:0]    p_v;

   always_comb begin
      lum_sh = Q2W'(c_lum_ff) << HB;
      if (c_lum_ff[HB:HB-1] == 2'b00) begin
         q2 = lum_sh + Q2W'(c_ls_ff);
      end else begin
         q2 = lum_sh + (Q2W'(c_sat_ff) << HB) - Q2W'(c_ls_ff);
      end
      q2r = q2 + (Q2W'(1) << (HB - 1));
      q_v = q2r[2*HB:HB];
      p_v = {c_lum_ff, 1'b0} - {1'b0, q_v};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_q_ff  <= q_v;
         d_p_ff  <= p_v[LW-1:0];
         d_hs_ff <= c_hs_ff;
      end
   end

   // ---------------- stage e: per-channel hue position and weight ----------------
   logic          e_vld_ff;
   logic [LW-1:0] e_p_ff, e_d_ff;
   logic [LW-1:0] e_w_ff [3];
   logic [LW-1:0] w_v [3];
   logic [UW-1:0] six_hs;

   always_comb begin
      logic [UW-1:0] u0, u;
      six_hs = (UW'(d_hs_ff) << 2) + (UW'(d_hs_ff) << 1);
      for (int ch = 0; ch < 3; ch++) begin
         u0 = six_hs + (UW'(CH_OFS[ch]) << HB);
         u  = (u0 >= 6 * ONE_U) ? (u0 - 6 * ONE_U) : u0;
         // rising edge, plateau, falling edge, floor
         if (u < ONE_U) begin
            w_v[ch] = LW'(u);
         end else if (u < 3 * ONE_U) begin
            w_v[ch] = ONE_L;
         end else if (u < 4 * ONE_U) begin
            w_v[ch] = LW'(4 * ONE_U - u);
         end else begin
            w_v[ch] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_p_ff <= d_p_ff;
         e_d_ff <= d_q_ff - d_p_ff;
         for (int ch = 0; ch < 3; ch++) e_w_ff[ch] <= w_v[ch];
      end
   end

   // ---------------- stage f: (q-p)*w ----------------
   logic          f_vld_ff;
   logic [LW-1:0] f_p_ff;
   logic [MW-1:0] f_m_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_p_ff <= e_p_ff;
         for (int ch = 0; ch < 3; ch++) f_m_ff[ch] <= MW'(e_d_ff) * MW'(e_w_ff[ch]);
      end
   end

   // ---------------- stage g: v = p*ONE + m ----------------
   logic          g_vld_ff;
   logic [MW-1:0] g_v_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ch = 0; ch < 3; ch++) g_v_ff[ch] <= (MW'(f_p_ff) << HB) + f_m_ff[ch];
      end
   end

   // ---------------- stage h: scale by 255 and round to a byte ----------------
   logic [7:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [7:0] byte_v [3];

   always_comb begin
      logic [VW-1:0] vx;
      for (int ch = 0; ch < 3; ch++) begin
         vx = (VW'(g_v_ff[ch]) << 8) - VW'(g_v_ff[ch]) + (VW'(1) << (2 * HB - 1));
         byte_v[ch] = vx[2*HB+7:2*HB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff   <= byte_v[0];
         rsp_green_ff <= byte_v[1];
         rsp_blue_ff  <= byte_v[2];
      end
   end

   assign rsp_red_out   = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out  = rsp_blue_ff;

`ifndef SYNTHESIS
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (h_vld_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while result stalled");

   a_lum_sat_range : assert property (@(posedge clock) disable iff (reset)
      b_vld_ff |-> (b_lum_ff <= ONE_L && b_sat_ff <= ONE_L))
      else $error("lightness or saturation above one");

   a_p_not_above_q : assert property (@(posedge clock) disable iff (reset)
      d_vld_ff |-> (d_p_ff <= d_q_ff && d_q_ff <= ONE_L))
      else $error("p above q or q above one");
`endif

endmodule
`default_nettype wire

// File: test/tb_rgb_hue_rotate_via_hsl.sv
// Testbench for the RGB hue rotation block: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
module tb_rgb_hue_rotate_via_hsl
   import rgbhr_pkg::*;
();

   localparam int HB = HUE_BITS_DEF;
   localparam longint ONE = 64'd1 << HB;
   localparam int LATENCY = HB + 10;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rgb_hue_rotate_via_hsl dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pixel_type pending_pixels[$];
   pixel_type rotated_pixels[$];
   logic [15:0] hue_shift_now = '0;
   int  errors = 0;
   int  cycles = 0;
   int  gap_left = 0;
   int  burst_left = 0;
   bit  driver_on = 1'b0;
   int  stall_mode = 0;

   function automatic logic [7:0] channel_value(longint p, longint q, longint hs, longint c);
      longint u;
      longint v;
      u = (6 * hs + c * ONE) % (6 * ONE);
      if (u < ONE) v = p * ONE + (q - p) * u;
      else if (u < 3 * ONE) v = q * ONE;
      else if (u < 4 * ONE) v = p * ONE + (q - p) * (4 * ONE - u);
      else v = p * ONE;
      // v*255 fits in 64 bits unsigned for HB = 16
      return 8'((64'(v) * 255 + ((ONE * ONE) >> 1)) >> (2 * HB));
   endfunction

   function automatic pixel_type rotate_hue(pixel_type px, logic [15:0] shift_reg);
      longint r, g, b, mx, mn, diff, sum, lum, sat, hue, den, num, q2, q, p;
      pixel_type res;
      r = px.red; g = px.green; b = px.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      diff = mx - mn;
      sum = mx + mn;
      lum = (2 * sum * ONE + 510) / 1020;
      sat = 0;
      hue = 0;
      if (diff != 0) begin
         den = (sum <= 255) ? sum : (510 - sum);
         sat = (2 * diff * ONE + den) / (2 * den);
         if (mx == r) num = (g >= b) ? (g - b) : (6 * diff - (b - g));
         else if (mx == g) num = 2 * diff + b - r;
         else num = 4 * diff + r - g;
         hue = ((2 * num * ONE + 6 * diff) / (12 * diff)) % ONE;
      end
      hue = (hue + (longint'(shift_reg) << (HB - 16))) % ONE;
      if (2 * lum < ONE) q2 = lum * (ONE + sat);
      else q2 = lum * ONE + sat * ONE - lum * sat;
      q = (q2 + (ONE >> 1)) >> HB;
      p = 2 * lum - q;
      res.red = channel_value(p, q, hue, CH_OFS[0]);
      res.green = channel_value(p, q, hue, CH_OFS[1]);
      res.blue = channel_value(p, q, hue, CH_OFS[2]);
      return res;
   endfunction

   // driver: bursts and gaps, valid held until the transaction completes
   always @(posedge clock) begin
      if (!(req_valid && !req_ready)) begin
         if (driver_on && pending_pixels.size() > 0 && gap_left == 0) begin
            pixel_type px;
            px = pending_pixels.pop_front();
            req_valid <= 1'b1;
            req_red_in <= px.red;
            req_green_in <= px.green;
            req_blue_in <= px.blue;
            rotated_pixels.push_back(rotate_hue(px, hue_shift_now));
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left = gap_left - 1;
         end
      end
   end

   // receiver stall pattern and result check
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= ((cycles % 8) < 3);
      endcase
      if (rsp_valid && rsp_ready) begin
         if (rotated_pixels.size() == 0) begin
            $error("unexpected transaction %h %h %h", rsp_red_out, rsp_green_out,
                   rsp_blue_out);
            errors++;
         end else begin
            pixel_type e;
            e = rotated_pixels.pop_front();
            if (rsp_red_out !== e.red) begin
               $error("red_out expected %0d got %0d", e.red, rsp_red_out);
               errors++;
            end
            if (rsp_green_out !== e.green) begin
               $error("green_out expected %0d got %0d", e.green, rsp_green_out);
               errors++;
            end
            if (rsp_blue_out !== e.blue) begin
               $error("blue_out expected %0d got %0d", e.blue, rsp_blue_out);
               errors++;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_hue_shift(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(REG_HUE_SHIFT) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      hue_shift_now = value[15:0];
   endtask

   task automatic run_phase();
      driver_on = 1'b1;
      while (pending_pixels.size() > 0 || rotated_pixels.size() > 0) @(posedge clock);
      driver_on = 1'b0;
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic pixel_type make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_type px;
      px.red = r; px.green = g; px.blue = b;
      return px;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      logic [7:0] base;
      base = 8'($urandom);
      px = pixel_type'(24'($urandom));
      // bias some pixels to grey, near-grey and saturated extremes
      case ($urandom_range(0, 9))
         0: px = make_pixel(base, base, base);
         1: px = make_pixel(base, base ^ 8'($urandom_range(0, 1)), base);
         2: px = make_pixel(8'(8'hFF * $urandom_range(0, 1)),
                            8'(8'hFF * $urandom_range(0, 1)), 8'($urandom));
         default: ;
      endcase
      return px;
   endfunction

   logic [15:0] shift_list[8];

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: greys, primaries, secondaries, ties and extremes at reset shift
      pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'h00));
      pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF));
      pending_pixels.push_back(make_pixel(8'h80, 8'h80, 8'h80));
      pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'h00));
      pending_pixels.push_back(make_pixel(8'h00, 8'hFF, 8'h00));
      pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'hFF));
      pending_pixels.push_back(make_pixel(8'hFF, 8'hFF, 8'h00));
      pending_pixels.push_back(make_pixel(8'h00, 8'hFF, 8'hFF));
      pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'hFF));
      pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'h01));
      pending_pixels.push_back(make_pixel(8'h01, 8'h00, 8'h00));
      pending_pixels.push_back(make_pixel(8'hFE, 8'hFF, 8'hFF));
      pending_pixels.push_back(make_pixel(8'h7F, 8'h80, 8'h80));
      pending_pixels.push_back(make_pixel(8'h12, 8'hA5, 8'h5A));
      run_phase();
      shift_list = '{16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h0000,
                     16'h2AAB, 16'h0000};
      shift_list[7] = 16'($urandom);
      for (int ph = 0; ph < 8; ph++) begin
         // upper bits are ignored by the block
         write_hue_shift({16'($urandom), shift_list[ph]});
         pending_pixels.push_back(make_pixel(8'hFF, 8'h00, 8'h00));
         pending_pixels.push_back(make_pixel(8'h00, 8'h00, 8'hFF));
         for (int i = 0; i < 200; i++) pending_pixels.push_back(random_pixel());
         run_phase();
      end
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
